[design/crcfc_pkg.sv]
// Package for the CRC-16 frame checker: types, constants and the CRC step function.
package crcfc_pkg;

	localparam int NumIds = 5;

	localparam logic [2:0] KIND_STATUS   = 3'd0;
	localparam logic [2:0] KIND_IMU_RAW  = 3'd1;
	localparam logic [2:0] KIND_IMU_CALC = 3'd2;
	localparam logic [2:0] KIND_REMOTE   = 3'd3;
	localparam logic [2:0] KIND_GPS      = 3'd4;
	localparam logic [2:0] KIND_UNKNOWN  = 3'd5;

	localparam logic [2:0] REG_ID_STATUS   = 3'd0;
	localparam logic [2:0] REG_ID_IMU_RAW  = 3'd1;
	localparam logic [2:0] REG_ID_IMU_CALC = 3'd2;
	localparam logic [2:0] REG_ID_REMOTE   = 3'd3;
	localparam logic [2:0] REG_ID_GPS      = 3'd4;

	localparam logic [7:0] ID_RESET [NumIds] = '{8'd2, 8'd3, 8'd4, 8'd5, 8'd35};

	localparam logic [15:0] CRC_INIT = 16'h00FF;

	localparam logic [8:0] POS_LENGTH     = 9'd3;
	localparam logic [8:0] POS_DESCRIPTOR = 9'd5;
	localparam logic [8:0] POS_PAYLOAD    = 9'd6;

	typedef struct packed {
		logic       frame_good;
		logic       crc_match;
		logic [2:0] kind;
		logic [7:0] descriptor;
		logic [7:0] payload_length;
	} res_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] index;
		logic [7:0] data;
	} cfg_wr_t;

	// byte-wise reflected CCITT CRC-16 (0x8408)
	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [7:0] d;
		logic [7:0] e;
		d = b ^ crc[7:0];
		e = d ^ {d[3:0], 4'b0000};
		return {e, crc[15:8]} ^ {12'b0, e[7:4]} ^ {5'b0, e, 3'b000};
	endfunction

endpackage

[design/crc16_frame_checker.sv]
// Top level of the CRC-16 frame checker: input register, parser, ID match, result register.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    tdata rx_byte, tuser frame_start
//  m_*      out  m_tvalid/m_tready    tdata flags/descriptor/length, tuser kind
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One byte per cycle unless m_tready stalls; each result passes input and result registers.
// The input register advances when it is empty or the result register is empty or being taken.
// A stall on m_tready backs up through the single input register to s_tready.
// Reset: IDs at defaults, no frame open; cfg_ready is always high.
module crc16_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [0] frame_good, [1] crc_match, [9:2] descriptor,
	                               // [17:10] payload_length, [23:18] zero
	output logic [2:0]  m_tuser,   // [2:0] kind
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import crcfc_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;
	logic       adv;
	logic       res_valid_q;
	res_t       res_q;
	logic       res_valid;
	res_t       res;
	logic [7:0] descriptor;
	logic [2:0] kind;
	cfg_wr_t    cfg_wr;

	assign adv       = !res_valid_q || m_tready;
	assign s_tready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	assign cfg_wr.valid = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1  <= s_tdata;
			start_s1 <= s_tuser;
		end
	end

	crcfc_id_match u_id_match (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr     (cfg_wr),
		.descriptor (descriptor),
		.kind       (kind)
	);

	crcfc_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (valid_s1 && adv),
		.rx_byte     (byte_s1),
		.frame_start (start_s1),
		.kind        (kind),
		.descriptor  (descriptor),
		.res_valid   (res_valid),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) res_q <= res;
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {6'b0, res_q.payload_length, res_q.descriptor,
		res_q.crc_match, res_q.frame_good};
	assign m_tuser  = res_q.kind;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("input stalled without a blocked result");

	a_good_needs_crc: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> m_tdata[1])
		else $error("frame_good without crc_match");

	a_good_needs_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tuser != KIND_UNKNOWN))
		else $error("frame_good with unknown kind");

endmodule

[design/crcfc_id_match.sv]
// Descriptor ID registers and priority classification of the frame descriptor.
module crcfc_id_match (
	input  logic                 clk,
	input  logic                 arst_n,
	input  crcfc_pkg::cfg_wr_t   cfg_wr,
	input  logic [7:0]           descriptor,
	output logic [2:0]           kind
);
	import crcfc_pkg::*;

	logic [7:0] id_q [NumIds];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumIds; i++) id_q[i] <= ID_RESET[i];
		end else if (cfg_wr.valid) begin
			unique case (cfg_wr.index)
				REG_ID_STATUS:   id_q[0] <= cfg_wr.data;
				REG_ID_IMU_RAW:  id_q[1] <= cfg_wr.data;
				REG_ID_IMU_CALC: id_q[2] <= cfg_wr.data;
				REG_ID_REMOTE:   id_q[3] <= cfg_wr.data;
				REG_ID_GPS:      id_q[4] <= cfg_wr.data;
				default: ;
			endcase
		end
	end

	// lowest index wins on duplicates
	always_comb begin
		kind = KIND_UNKNOWN;
		for (int i = NumIds - 1; i >= 0; i--) begin
			if (id_q[i] == descriptor) kind = 3'(i);
		end
	end

endmodule

[design/crcfc_parser.sv]
// Frame parser: byte position tracking, held fields, running CRC and result build.
module crcfc_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          rx_byte,
	input  logic                frame_start,
	input  logic [2:0]          kind,
	output logic [7:0]          descriptor,
	output logic                res_valid,
	output crcfc_pkg::res_t     res
);
	import crcfc_pkg::*;

	logic        in_frame_q;
	logic [8:0]  pos_q;
	logic [7:0]  len_q;
	logic [7:0]  desc_q;
	logic [15:0] crc_q;
	logic [7:0]  sum_lo_q;

	logic [8:0]  pay_end;
	logic [8:0]  pay_last;
	logic        crc_ok;

	assign pay_end  = POS_PAYLOAD + {1'b0, len_q};
	assign pay_last = pay_end + 9'd1;
	assign crc_ok   = ({rx_byte, sum_lo_q} == crc_q);
	assign descriptor = desc_q;

	always_comb begin
		res.crc_match      = crc_ok;
		res.kind           = kind;
		res.frame_good     = crc_ok && (kind != KIND_UNKNOWN);
		res.descriptor     = desc_q;
		res.payload_length = len_q;
		res_valid = fire && !frame_start && in_frame_q && (pos_q == pay_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q      <= '0;
			len_q      <= '0;
			desc_q     <= '0;
			crc_q      <= CRC_INIT;
			sum_lo_q   <= '0;
		end else if (fire) begin
			if (frame_start) begin
				in_frame_q <= 1'b1;
				pos_q      <= 9'd1;
				len_q      <= '0;
				desc_q     <= '0;
				crc_q      <= CRC_INIT;
				sum_lo_q   <= '0;
			end else if (in_frame_q) begin
				pos_q <= pos_q + 9'd1;
				if (pos_q == POS_LENGTH) begin
					len_q <= rx_byte;
				end else if (pos_q == POS_DESCRIPTOR) begin
					desc_q <= rx_byte;
				end else if (pos_q >= POS_PAYLOAD && pos_q < pay_end) begin
					crc_q <= crc_step(crc_q, rx_byte);
				end else if (pos_q == pay_end) begin
					sum_lo_q <= rx_byte;
				end else if (pos_q == pay_last) begin
					in_frame_q <= 1'b0;
					pos_q      <= '0;
				end
			end
		end
	end

endmodule

[test/crc16_frame_checker_chk.sv]
// Frame verdict scoreboard for crc16_frame_checker, with the CRC helper it shares with the bench.
package crc16_tb_pkg;

	// reflected CCITT CRC-16, one bit at a time
	function automatic logic [15:0] ccitt_refl_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ 16'h8408) : (c >> 1);
		end
		return c;
	endfunction

endpackage

module crc16_frame_checker_chk
	import crcfc_pkg::*;
	import crc16_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	output int          fail_count,
	output int          open_count
);

	logic [7:0]  id_table [NumIds];
	logic        frame_open;
	logic [8:0]  byte_pos;
	logic [7:0]  length_byte;
	logic [7:0]  descriptor_byte;
	logic [7:0]  checksum_low;
	logic [15:0] crc_acc;
	res_t        verdicts_q [$];
	res_t        seen;
	res_t        oldest;

	initial fail_count = 0;
	initial open_count = 0;

	function automatic string show(input res_t r);
		return $sformatf("good=%0d match=%0d kind=%0d desc=%02h len=%0d",
			r.frame_good, r.crc_match, r.kind, r.descriptor, r.payload_length);
	endfunction

	task automatic flag_error(input string what);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: %s", $time, what);
		end
	endtask

	task automatic parse_byte(input logic [7:0] b, input logic st);
		logic [8:0] at;
		logic [8:0] pay_end;
		logic [2:0] kind;
		res_t       want;
		if (st) begin
			frame_open      = 1'b1;
			byte_pos        = 9'd1;
			crc_acc         = CRC_INIT;
			length_byte     = '0;
			descriptor_byte = '0;
			checksum_low    = '0;
		end else if (frame_open) begin
			at       = byte_pos;
			pay_end  = POS_PAYLOAD + 9'(length_byte);
			byte_pos = at + 9'd1;
			if (at == POS_LENGTH) begin
				length_byte = b;
			end else if (at == POS_DESCRIPTOR) begin
				descriptor_byte = b;
			end else if (at >= POS_PAYLOAD && at < pay_end) begin
				crc_acc = ccitt_refl_update(crc_acc, b);
			end else if (at == pay_end) begin
				checksum_low = b;
			end else if (at == pay_end + 9'd1) begin
				// lowest matching register wins
				kind = KIND_UNKNOWN;
				for (int k = NumIds - 1; k >= 0; k--) begin
					if (id_table[k] == descriptor_byte) kind = 3'(k);
				end
				want.crc_match      = ({b, checksum_low} == crc_acc);
				want.kind           = kind;
				want.frame_good     = want.crc_match && (kind != KIND_UNKNOWN);
				want.descriptor     = descriptor_byte;
				want.payload_length = length_byte;
				verdicts_q.push_back(want);
				frame_open = 1'b0;
				byte_pos   = '0;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NumIds; k++) begin
				id_table[k] = ID_RESET[k];
			end
			frame_open      = 1'b0;
			byte_pos        = '0;
			length_byte     = '0;
			descriptor_byte = '0;
			checksum_low    = '0;
			crc_acc         = CRC_INIT;
			verdicts_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				seen = {m_tdata[0], m_tdata[1], m_tuser, m_tdata[9:2], m_tdata[17:10]};
				if (verdicts_q.size() == 0) begin
					flag_error($sformatf("unexpected result %s", show(seen)));
				end else begin
					oldest = verdicts_q.pop_front();
					if (seen.frame_good !== oldest.frame_good ||
					    seen.crc_match !== oldest.crc_match ||
					    seen.kind !== oldest.kind ||
					    seen.descriptor !== oldest.descriptor ||
					    seen.payload_length !== oldest.payload_length) begin
						flag_error($sformatf("expected %s, got %s", show(oldest), show(seen)));
					end
				end
			end
			if (cfg_valid && cfg_ready && cfg_index < NumIds) begin
				id_table[cfg_index] = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata, s_tuser);
			end
		end
		open_count = verdicts_q.size();
	end

endmodule

[test/tb_crc16_frame_checker.sv]
// Testbench top for crc16_frame_checker: clock, reset, frame stimulus, ID setup and verdict.
module tb_crc16_frame_checker;
	import crcfc_pkg::*;
	import crc16_tb_pkg::*;

	localparam int RandomBytes  = 1450;
	localparam int Phases       = 8;
	localparam int QuietPhase   = 4;
	localparam int SettleCycles = 8;
	localparam int CycleLimit   = 200000;

	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b1;
	logic [23:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;

	int         fail_count;
	int         open_count;
	int         cycle_count = 0;
	bit         quiet = 1'b0;
	logic [7:0] ids_now [NumIds];
	logic [8:0] byte_q [$];   // [8] frame_start, [7:0] byte

	crc16_frame_checker u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	crc16_frame_checker_chk u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.open_count(open_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	always @(posedge clk) m_tready <= quiet || ($urandom_range(0, 99) >= 27);

	initial begin
		wait (cycle_count >= CycleLimit);
		$display("tb_crc16_frame_checker NOT OK");
		$finish;
	end

	function automatic int random_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return $urandom_range(0, 8);
		if (r < 92) return $urandom_range(9, 40);
		if (r < 98) return $urandom_range(41, 120);
		return $urandom_range(200, 255);
	endfunction

	function automatic logic [7:0] pick_desc();
		if ($urandom_range(0, 99) < 70) return ids_now[$urandom_range(0, NumIds - 1)];
		return 8'($urandom);
	endfunction

	task automatic add_frame(input int len, input logic [7:0] desc, input bit good);
		logic [15:0] crc;
		logic [7:0]  b;
		crc = CRC_INIT;
		byte_q.push_back({1'b1, 8'($urandom)});
		byte_q.push_back({1'b0, 8'($urandom)});
		byte_q.push_back({1'b0, 8'($urandom)});
		byte_q.push_back({1'b0, 8'(len)});
		byte_q.push_back({1'b0, 8'($urandom)});
		byte_q.push_back({1'b0, desc});
		for (int i = 0; i < len; i++) begin
			b   = 8'($urandom);
			crc = ccitt_refl_update(crc, b);
			byte_q.push_back({1'b0, b});
		end
		if (!good) crc ^= 16'($urandom_range(1, 16'hFFFF));
		byte_q.push_back({1'b0, crc[7:0]});
		byte_q.push_back({1'b0, crc[15:8]});
	endtask

	// mostly clean frames; some cut short, some loose bytes
	task automatic add_traffic();
		int r;
		r = $urandom_range(0, 99);
		if (r < 85) begin
			add_frame(random_len(), pick_desc(), $urandom_range(0, 99) < 80);
		end else if (r < 93) begin
			add_frame(random_len(), pick_desc(), 1'b1);
			repeat ($urandom_range(1, byte_q.size() - 1)) void'(byte_q.pop_back());
		end else begin
			repeat ($urandom_range(1, 4)) byte_q.push_back({($urandom_range(0, 9) == 0), 8'($urandom)});
		end
	endtask

	task automatic send_next();
		logic [8:0] x;
		x = byte_q.pop_front();
		while (!quiet && $urandom_range(0, 99) < 27) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= x[7:0];
		s_tuser  <= x[8];
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		if (idx < NumIds) ids_now[idx] = val;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (open_count != 0) @(negedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic configure(input int phase);
		case (phase)
			1: begin
				for (int i = 0; i < NumIds; i++) write_reg(3'(i), 8'h00);
				write_reg(REG_SPARE_LO, 8'hAA);
			end
			2: begin
				for (int i = 0; i < NumIds; i++) write_reg(3'(i), 8'hFF);
				write_reg(REG_SPARE_HI, 8'h00);
			end
			4: begin
				for (int i = 0; i < NumIds; i++) write_reg(3'(i), 8'($urandom_range(0, 3)));
			end
			5: begin
				for (int i = 0; i < NumIds; i++) write_reg(3'(i), ID_RESET[i]);
				write_reg(REG_SPARE_HI, 8'($urandom));
			end
			7: begin
				write_reg(REG_ID_GPS, 8'h00);
				write_reg(REG_ID_STATUS, 8'hFF);
				write_reg(REG_ID_REMOTE, 8'($urandom));
			end
			default: begin
				for (int i = 0; i < NumIds; i++) write_reg(3'(i), 8'($urandom));
			end
		endcase
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int sent;
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		for (int i = 0; i < NumIds; i++) ids_now[i] = ID_RESET[i];
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		byte_q.push_back({1'b0, 8'hFF});          // loose byte, no frame open
		add_frame(0, ID_RESET[REG_ID_GPS], 1'b1); // empty payload
		byte_q.push_back({1'b1, 8'h00});          // cut off by the next start
		byte_q.push_back({1'b0, 8'hFF});
		byte_q.push_back({1'b0, 8'h00});
		byte_q.push_back({1'b0, 8'h01});
		add_frame(1, 8'hFF, 1'b1);                // unknown descriptor
		while (byte_q.size() != 0) send_next();

		// a frame left open at a phase boundary spans the ID update
		sent = 0;
		for (int p = 0; p < Phases; p++) begin
			settle();
			if (p > 0) configure(p);
			quiet = (p == QuietPhase);
			while (sent < RandomBytes * (p + 1) / Phases ||
			       (p == Phases - 1 && byte_q.size() != 0)) begin
				if (byte_q.size() == 0) add_traffic();
				send_next();
				sent++;
			end
		end
		settle();

		if (fail_count == 0) begin
			$display("tb_crc16_frame_checker OK");
		end else begin
			$display("tb_crc16_frame_checker NOT OK");
		end
		$finish;
	end

endmodule
